// ===== rtl/mpsm_pkg.sv =====
package mpsm_pkg;

    localparam int VEC_WORDS     = 8;
    localparam int ALPHABET_SIZE = 128;

    localparam int DATA_W     = 32;
    localparam int CHAR_W     = 7;
    localparam int WIDX_W     = 3;
    localparam int OP_W       = 2;
    localparam int WORD_W     = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
    localparam int CHAR_IDX_W = $clog2(ALPHABET_SIZE);
    localparam int RAM_DEPTH  = ALPHABET_SIZE << WORD_W;
    localparam int ADDR_W     = CHAR_IDX_W + WORD_W;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TEXT      = 2'd0,
        OP_CHAR_MASK = 2'd1,
        OP_START     = 2'd2,
        OP_END       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              wr_start;
        logic              wr_end;
        logic [WORD_W-1:0] wr_word;
        logic [DATA_W-1:0] wr_data;
        logic              step;
        logic              first;
        logic              zero_mask;
        logic [WORD_W-1:0] step_word;
    } dp_ctrl_t;

endpackage

// ===== rtl/mpsm_ram.sv =====
module mpsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mpsm_datapath.sv =====
module mpsm_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mpsm_pkg::dp_ctrl_t        ctrl,
    input  logic [mpsm_pkg::DATA_W-1:0] mask_data,
    output logic                      hit
);
    import mpsm_pkg::*;

    logic [DATA_W-1:0] active_reg [VEC_WORDS];
    logic [DATA_W-1:0] start_reg  [VEC_WORDS];
    logic [DATA_W-1:0] end_reg    [VEC_WORDS];
    logic              carry_reg;
    logic              hit_reg;

    logic [DATA_W-1:0] old_word;
    logic [DATA_W-1:0] new_word;
    logic              carry_in;
    logic              hit_next;
    logic              carry_next;

    always_comb
    begin
        old_word   = active_reg[ctrl.step_word];
        carry_in   = ctrl.first ? 1'b0 : carry_reg;
        new_word   = ((old_word << 1) | start_reg[ctrl.step_word]
                      | {{(DATA_W-1){1'b0}}, carry_in})
                     & (ctrl.zero_mask ? '0 : mask_data);
        carry_next = old_word[DATA_W-1];
        hit_next   = (ctrl.first ? 1'b0 : hit_reg)
                     | (|(new_word & end_reg[ctrl.step_word]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VEC_WORDS; i++)
            begin
                active_reg[i] <= '0;
                start_reg[i]  <= '0;
                end_reg[i]    <= '0;
            end
            carry_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_start)
            begin
                start_reg[ctrl.wr_word] <= ctrl.wr_data;
            end
            if (ctrl.wr_end)
            begin
                end_reg[ctrl.wr_word] <= ctrl.wr_data;
            end
            if (ctrl.step)
            begin
                active_reg[ctrl.step_word] <= new_word;
                carry_reg                  <= carry_next;
                hit_reg                    <= hit_next;
            end
        end
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/mpsm_seq.sv =====
module mpsm_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mpsm_pkg::OP_W-1:0]      op_in,
    input  logic [mpsm_pkg::CHAR_W-1:0]    char_in,
    input  logic [mpsm_pkg::WIDX_W-1:0]    word_in,
    input  logic [mpsm_pkg::DATA_W-1:0]    mask_in,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic                           match,
    output logic                           ram_we,
    output logic [mpsm_pkg::ADDR_W-1:0]    ram_waddr,
    output logic [mpsm_pkg::DATA_W-1:0]    ram_wdata,
    output logic                           ram_re,
    output logic [mpsm_pkg::ADDR_W-1:0]    ram_raddr,
    output mpsm_pkg::dp_ctrl_t             ctrl,
    input  logic                           hit
);
    import mpsm_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                mval_reg, mval_next;
    logic                match_reg, match_next;

    op_t                 op;
    logic                accept;
    logic                load_ok;
    logic                ch_reg_ok;
    logic                last_word;
    logic                out_free;
    logic [WORD_W-1:0]   word_succ;

    assign op        = op_t'(op_in);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign load_ok   = (int'(word_in) < VEC_WORDS);
    assign ch_reg_ok = (int'(ch_reg) < ALPHABET_SIZE);
    assign last_word = (word_reg == WORD_W'(VEC_WORDS - 1));
    assign out_free  = !mval_reg || m_axis_tready;
    assign word_succ = word_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(RAM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && op == OP_TEXT)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_word)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready  = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = {CHAR_IDX_W'(char_in), WORD_W'(word_in)};
        ram_wdata      = mask_in;
        ram_re         = 1'b0;
        ram_raddr      = {CHAR_IDX_W'(char_in), WORD_W'(0)};
        ctrl           = '0;
        ctrl.wr_word   = WORD_W'(word_in);
        ctrl.wr_data   = mask_in;
        ctrl.step_word = word_reg;
        ctrl.first     = (word_reg == '0);
        ctrl.zero_mask = !ch_reg_ok;
        clr_cnt_next   = clr_cnt_reg;
        word_next      = word_reg;
        ch_next        = ch_reg;
        mval_next      = mval_reg && !m_axis_tready;
        match_next     = match_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    case (op)
                        OP_TEXT:
                        begin
                            ram_re    = 1'b1;
                            word_next = '0;
                            ch_next   = char_in;
                        end
                        OP_CHAR_MASK:
                        begin
                            ram_we = load_ok && (int'(char_in) < ALPHABET_SIZE);
                        end
                        OP_START:
                        begin
                            ctrl.wr_start = load_ok;
                        end
                        OP_END:
                        begin
                            ctrl.wr_end = load_ok;
                        end
                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                ctrl.step = 1'b1;
                ram_re    = !last_word;
                ram_raddr = {CHAR_IDX_W'(ch_reg), word_succ};
                word_next = word_succ;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    mval_next  = 1'b1;
                    match_next = hit;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            word_reg    <= '0;
            mval_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            word_reg    <= word_next;
            mval_reg    <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        match_reg <= match_next;
    end

    assign m_axis_tvalid = mval_reg;
    assign match         = match_reg;

endmodule

// ===== rtl/multi_pattern_shift_and_matcher_top.sv =====
// Multi-pattern Shift-And matcher with a 32-bit state word updated per cycle.
// Input transactions arrive on the s_axis channel. tuser carries the operation:
// a text character, or a load of one word of a character mask, the start mask
// or the end mask. Loads produce no output transaction. A text character
// walks the VEC_WORDS state words through one shared update unit, one word
// per cycle, reading that character's mask words from a mask RAM with a
// registered read. The character is accepted in the idle state, its words
// are stepped in the run state, and the done state loads the match result
// into the output register on m_axis; the block then returns to idle, so no
// new input transaction is taken while a character is in flight. After reset
// the block clears all ALPHABET_SIZE * VEC_WORDS (1024) mask RAM words, one
// word per cycle, with s_axis_tready low; the start, end and state words
// clear at once. The result sits in an output register; if the receiver
// stalls, one more character may be computed, and the block then waits
// with s_axis_tready low until the pending result is taken.
module multi_pattern_shift_and_matcher_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // character [6:0], word_index [9:7], mask_word [41:10], zero fill above
    input  logic [mpsm_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // operation [1:0]
    input  logic [mpsm_pkg::OP_W-1:0]              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // match [0], zero fill above
    output logic [mpsm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import mpsm_pkg::*;

    logic [CHAR_W-1:0] char_in;
    logic [WIDX_W-1:0] word_in;
    logic [DATA_W-1:0] mask_in;
    logic              match;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    dp_ctrl_t          ctrl;
    logic              hit;

    assign char_in = s_axis_tdata[CHAR_W-1:0];
    assign word_in = s_axis_tdata[CHAR_W+WIDX_W-1:CHAR_W];
    assign mask_in = s_axis_tdata[CHAR_W+WIDX_W+DATA_W-1:CHAR_W+WIDX_W];

    mpsm_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .op_in         (s_axis_tuser),
        .char_in       (char_in),
        .word_in       (word_in),
        .mask_in       (mask_in),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .match         (match),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ctrl          (ctrl),
        .hit           (hit)
    );

    mpsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mpsm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .mask_data (ram_rdata),
        .hit       (hit)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, match};

endmodule

// ===== rtl/mpsm_checker.sv =====
module mpsm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [mpsm_pkg::OP_W-1:0]        s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mpsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mpsm_pkg::*;

    // A text character occupies the update unit, so nothing is taken right after it.
    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TEXT) |=> !s_axis_tready)
    else $error("input accepted right after a text character");

    // A new result is only produced while the input side is closed.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input was open");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("nonzero fill bits in output data");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed under stall");

endmodule

bind multi_pattern_shift_and_matcher_top mpsm_checker u_mpsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
